// File: hdl/b64d_pkg.sv
// Shared constants, types and the character classifier of the base64 stream decoder.
package b64d_pkg;

    localparam int LEN_BITS = 10;
    localparam int CAP_W    = 10;
    localparam int SUM_W    = ((LEN_BITS > CAP_W) ? LEN_BITS : CAP_W) + 1;
    localparam int ACC_W    = 24;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [APB_AW-1:0] ADDR_OUT_CAPACITY = 3'd0;
    localparam logic [CAP_W-1:0]  CAP_RESET         = 10'd60;

    localparam logic [7:0] CLASS_SKIP = 8'd255;
    localparam logic [7:0] CLASS_PAD  = 8'd254;

    localparam logic [1:0] PAD_FULL = 2'd3;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MALFORMED = 2'd1,
        ERR_CAPACITY  = 2'd2
    } t_err;

    // One decoded group and/or the end-of-string status, as handed to the back end
    typedef struct packed {
        logic [1:0]          nbytes;
        logic [ACC_W-1:0]    group;
        logic                has_status;
        t_err                status;
        logic [LEN_BITS-1:0] len;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Map a character to its 6-bit symbol value, or to the pad / skip codes
    function automatic logic [7:0] classify(input logic [7:0] ch);
        logic [7:0] v;
        if (ch >= 8'd65 && ch <= 8'd90) begin          // 'A'..'Z'
            v = ch - 8'd65;
        end else if (ch >= 8'd97 && ch <= 8'd122) begin // 'a'..'z'
            v = ch - 8'd71;
        end else if (ch >= 8'd48 && ch <= 8'd57) begin  // '0'..'9'
            v = ch + 8'd4;
        end else if (ch == 8'd43) begin                 // '+'
            v = 8'd62;
        end else if (ch == 8'd47) begin                 // '/'
            v = 8'd63;
        end else if (ch == 8'd61) begin                 // '='
            v = CLASS_PAD;
        end else begin
            v = CLASS_SKIP;
        end
        return v;
    endfunction

endpackage

// File: hdl/b64d_if.sv
// Stream interfaces for text characters in and decoded results out.
interface b64d_in_if;
    import b64d_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface b64d_out_if;
    import b64d_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [7:0]          data_byte;
    logic [1:0]          status_code;
    logic [LEN_BITS-1:0] decoded_length;
    logic                run_end;

    modport source (output valid, output kind, output data_byte, output status_code,
                    output decoded_length, output run_end, input ready);
    modport sink   (input valid, input kind, input data_byte, input status_code,
                    input decoded_length, input run_end, output ready);
endinterface

// File: hdl/b64d_front.sv
// Front end: accepts characters, classifies them and runs the group / pad / error state.
module b64d_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    b64d_in_if.sink                      i_text,
    input  logic [b64d_pkg::CAP_W-1:0]   i_out_capacity,
    input  b64d_pkg::t_q_stat            i_q_stat,
    output logic                         o_push,
    output b64d_pkg::t_job               o_job
);
    import b64d_pkg::*;

    logic [ACC_W-1:0]    r_acc,   n_acc;
    logic [1:0]          r_syms,  n_syms;
    logic [1:0]          r_pad,   n_pad;
    logic [LEN_BITS-1:0] r_bytes, n_bytes;
    t_err                r_err,   n_err;

    logic       accept;
    logic [7:0] cls;
    logic [SUM_W-1:0] need;

    assign i_text.ready = !i_q_stat.full;
    assign accept       = i_text.valid && i_text.ready;
    assign cls          = classify(i_text.in_char);

    always_comb begin
        n_acc   = r_acc;
        n_syms  = r_syms;
        n_pad   = r_pad;
        n_bytes = r_bytes;
        n_err   = r_err;
        need    = '0;
        o_job   = '0;
        o_job.status = ERR_NONE;
        o_push  = 1'b0;
        if (accept) begin
            if (cls != CLASS_SKIP && r_err == ERR_NONE) begin
                if (cls == CLASS_PAD && r_pad <= 2'd1) begin
                    n_err = ERR_MALFORMED;
                end else if (cls != CLASS_PAD && r_pad != PAD_FULL) begin
                    n_err = ERR_MALFORMED;
                end else begin
                    // a pad shifts in as a zero symbol
                    if (cls == CLASS_PAD) begin
                        n_pad = r_pad - 2'd1;
                        n_acc = {r_acc[ACC_W-7:0], 6'd0};
                    end else begin
                        n_acc = {r_acc[ACC_W-7:0], cls[5:0]};
                    end
                    n_syms = r_syms + 2'd1;
                    if (n_syms == 2'd0) begin
                        need = SUM_W'(r_bytes) + SUM_W'(n_pad);
                        if (need > SUM_W'(i_out_capacity)) begin
                            n_err = ERR_CAPACITY;
                        end else begin
                            o_job.nbytes = n_pad;
                            o_job.group  = n_acc;
                            n_bytes      = r_bytes + LEN_BITS'(n_pad);
                            n_acc        = '0;
                        end
                    end
                end
            end
            if (i_text.end_of_text) begin
                if (n_err == ERR_NONE && n_syms != 2'd0) begin
                    n_err = ERR_MALFORMED;
                end
                o_job.has_status = 1'b1;
                o_job.status     = n_err;
                o_job.len        = n_bytes;
                // back to a fresh string
                n_acc   = '0;
                n_syms  = '0;
                n_pad   = PAD_FULL;
                n_bytes = '0;
                n_err   = ERR_NONE;
            end
            o_push = (o_job.nbytes != 2'd0) || o_job.has_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_syms  <= '0;
            r_pad   <= PAD_FULL;
            r_bytes <= '0;
            r_err   <= ERR_NONE;
        end else begin
            r_acc   <= n_acc;
            r_syms  <= n_syms;
            r_pad   <= n_pad;
            r_bytes <= n_bytes;
            r_err   <= n_err;
        end
    end

endmodule

// File: hdl/b64d_queue.sv
// Short job queue between the front end and the result serializer.
module b64d_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64d_pkg::t_job    i_job,
    input  logic              i_pop,
    output b64d_pkg::t_job    o_head,
    output b64d_pkg::t_q_stat o_stat
);
    import b64d_pkg::*;

    t_job               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/b64d_back.sv
// Back end: splits each queued job into result beats behind an output register.
module b64d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64d_pkg::t_job    i_head,
    input  b64d_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    b64d_out_if.source        o_result
);
    import b64d_pkg::*;

    logic [1:0]          r_beat, n_beat;
    logic                r_valid;
    logic                r_kind;
    logic [7:0]          r_data;
    logic [1:0]          r_status;
    logic [LEN_BITS-1:0] r_len;
    logic                r_last;

    logic       load, take, is_status, last_beat;
    logic [7:0] sel_byte;

    assign load      = !r_valid || o_result.ready;
    assign take      = load && !i_q_stat.empty;
    assign is_status = (r_beat == i_head.nbytes);
    assign last_beat = i_head.has_status ? is_status : (r_beat == i_head.nbytes - 2'd1);
    assign o_pop     = take && last_beat;
    assign n_beat    = o_pop ? 2'd0 : r_beat + 2'd1;

    always_comb begin
        case (r_beat)
            2'd0:    sel_byte = i_head.group[23:16];
            2'd1:    sel_byte = i_head.group[15:8];
            2'd2:    sel_byte = i_head.group[7:0];
            default: sel_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_q_stat.empty;
            end
            if (take) begin
                r_beat <= n_beat;
            end
        end
    end

    // hold the payload while the sink stalls
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_last <= last_beat;
            if (is_status) begin
                r_kind   <= KIND_STATUS;
                r_data   <= '0;
                r_status <= i_head.status;
                r_len    <= i_head.len;
            end else begin
                r_kind   <= KIND_DATA;
                r_data   <= sel_byte;
                r_status <= ERR_NONE;
                r_len    <= '0;
            end
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.kind           = r_kind;
    assign o_result.data_byte      = r_data;
    assign o_result.status_code    = r_status;
    assign o_result.decoded_length = r_len;
    assign o_result.run_end        = r_last;

endmodule

// File: hdl/base64_stream_decoder_top.sv
// Top level of the base64 stream decoder: configuration port and front/queue/back wiring.
//
// Takes one base64 text character per beat and may accept a new one every cycle while
// the output queue has room. Each accepted character is decoded in the cycle it is taken;
// a completed group of four symbols, and the status of a flagged final character, enter
// a four-entry job queue, and the result side drains it at one result beat per cycle
// while the sink is ready, through a registered output. A character gives up to four
// results (three bytes and the status), so the input stalls whenever four jobs wait in
// the queue.
// out_capacity is written through the APB port at byte address 0 and
// must be written only while the decoder holds no pending string.
module base64_stream_decoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [b64d_pkg::APB_AW-1:0]   paddr,
    input  logic [b64d_pkg::APB_DW-1:0]   pwdata,
    output logic [b64d_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    b64d_in_if.sink                       i_text,
    b64d_out_if.source                    o_result
);
    import b64d_pkg::*;

    logic [CAP_W-1:0] r_out_capacity;
    logic             push, pop;
    t_job             job, head;
    t_q_stat          q_stat;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_OUT_CAPACITY) ? APB_DW'(r_out_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_OUT_CAPACITY) begin
            r_out_capacity <= pwdata[CAP_W-1:0];
        end
    end

    b64d_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_text         (i_text),
        .i_out_capacity (r_out_capacity),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_job          (job)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

// File: dv/b64d_stream_checker.sv
// Checker for the base64 stream decoder: predicts result beats and compares them.
`timescale 1ns / 100ps

module b64d_stream_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [b64d_pkg::APB_AW-1:0] i_paddr,
    input  logic [b64d_pkg::APB_DW-1:0] i_pwdata,
    input  logic [b64d_pkg::APB_DW-1:0] i_prdata,
    input  logic                        i_pready,
    b64d_in_if                          i_text,
    b64d_out_if                         i_result,
    output int                          o_fail_count,
    output int                          o_pending
);
    import b64d_pkg::*;

    typedef struct packed {
        logic                kind;
        logic [7:0]          data_byte;
        t_err                status_code;
        logic [LEN_BITS-1:0] decoded_length;
        logic                run_end;
    } t_b64_result;

    t_b64_result         decoded_results[$];
    logic [CAP_W-1:0]    capacity;
    logic [ACC_W-1:0]    acc_bits;
    logic [1:0]          sym_count;
    logic [1:0]          pads_left;
    logic [LEN_BITS-1:0] byte_total;
    t_err                stream_err;
    int                  fails;

    function automatic logic [7:0] symbol_of(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return ch - "A";
        if (ch >= "a" && ch <= "z") return ch - "a" + 8'd26;
        if (ch >= "0" && ch <= "9") return ch - "0" + 8'd52;
        if (ch == "+") return 8'd62;
        if (ch == "/") return 8'd63;
        if (ch == "=") return CLASS_PAD;
        return CLASS_SKIP;
    endfunction

    task automatic clear_stream();
        acc_bits   = '0;
        sym_count  = '0;
        pads_left  = PAD_FULL;
        byte_total = '0;
        stream_err = ERR_NONE;
    endtask

    task automatic queue_result(input logic kind, input logic [7:0] data, input t_err status,
                                input logic [LEN_BITS-1:0] len);
        t_b64_result r;
        r.kind           = kind;
        r.data_byte      = data;
        r.status_code    = status;
        r.decoded_length = len;
        r.run_end        = 1'b0;
        decoded_results.push_back(r);
    endtask

    task automatic decode_char(input logic [7:0] ch, input logic last);
        logic [7:0] v;
        logic       take;
        int         n0;
        int         nbytes;
        n0 = decoded_results.size();
        v = symbol_of(ch);
        if (v != CLASS_SKIP && stream_err == ERR_NONE) begin
            take = 1'b1;
            if (v == CLASS_PAD) begin
                // a third pad is malformed
                if (pads_left <= 2'd1) begin
                    stream_err = ERR_MALFORMED;
                    take = 1'b0;
                end else begin
                    pads_left = pads_left - 2'd1;
                    v = 8'd0;
                end
            end else if (pads_left != PAD_FULL) begin
                stream_err = ERR_MALFORMED;
                take = 1'b0;
            end
            if (take) begin
                acc_bits  = {acc_bits[ACC_W-7:0], v[5:0]};
                sym_count = sym_count + 2'd1;
                if (sym_count == 2'd0) begin
                    // the pad budget stands in for the byte count of the group
                    if (int'(byte_total) + int'(pads_left) > int'(capacity)) begin
                        stream_err = ERR_CAPACITY;
                    end else begin
                        nbytes = 1;
                        queue_result(KIND_DATA, acc_bits[23:16], ERR_NONE, '0);
                        if (pads_left > 2'd1) begin
                            queue_result(KIND_DATA, acc_bits[15:8], ERR_NONE, '0);
                            nbytes++;
                        end
                        if (pads_left > 2'd2) begin
                            queue_result(KIND_DATA, acc_bits[7:0], ERR_NONE, '0);
                            nbytes++;
                        end
                        byte_total = byte_total + LEN_BITS'(nbytes);
                        acc_bits   = '0;
                    end
                end
            end
        end
        if (last) begin
            if (stream_err == ERR_NONE && sym_count != 2'd0) stream_err = ERR_MALFORMED;
            queue_result(KIND_STATUS, 8'd0, stream_err, byte_total);
            clear_stream();
        end
        if (decoded_results.size() > n0)
            decoded_results[decoded_results.size() - 1].run_end = 1'b1;
    endtask

    task automatic check_beat();
        t_b64_result want;
        if (decoded_results.size() == 0) begin
            $error("result beat with nothing expected: kind %0d data %0h status %0d len %0d",
                   i_result.kind, i_result.data_byte, i_result.status_code,
                   i_result.decoded_length);
            fails++;
        end else begin
            want = decoded_results.pop_front();
            if (i_result.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, i_result.kind);
                fails++;
            end
            if (i_result.data_byte !== want.data_byte) begin
                $error("data_byte: expected %0h, got %0h", want.data_byte, i_result.data_byte);
                fails++;
            end
            if (i_result.status_code !== want.status_code) begin
                $error("status_code: expected %0d, got %0d", want.status_code,
                       i_result.status_code);
                fails++;
            end
            if (i_result.decoded_length !== want.decoded_length) begin
                $error("decoded_length: expected %0d, got %0d", want.decoded_length,
                       i_result.decoded_length);
                fails++;
            end
            if (i_result.run_end !== want.run_end) begin
                $error("run_end: expected %0d, got %0d", want.run_end, i_result.run_end);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity = CAP_RESET;
            clear_stream();
            decoded_results.delete();
            fails = 0;
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == ADDR_OUT_CAPACITY) begin
                if (i_pwrite) begin
                    capacity = i_pwdata[CAP_W-1:0];
                end else if (i_prdata !== APB_DW'(capacity)) begin
                    $error("out_capacity: expected %0d, got %0d", capacity, i_prdata);
                    fails++;
                end
            end
            if (i_text.valid && i_text.ready) decode_char(i_text.in_char, i_text.end_of_text);
            if (i_result.valid && i_result.ready) check_beat();
        end
        o_fail_count <= fails;
        o_pending    <= decoded_results.size();
    end

endmodule

// File: dv/tb_base64_stream_decoder_top.sv
// Testbench top for the base64 stream decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_base64_stream_decoder_top;
    import b64d_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;

    logic [7:0]        text_q[$];
    bit                src_idle;
    bit                snk_idle;

    b64d_in_if  txt();
    b64d_out_if res();

    base64_stream_decoder_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_text   (txt),
        .o_result (res)
    );

    b64d_stream_checker checker_0 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .i_text       (txt),
        .i_result     (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: after a beat, while snk_idle is set, may drop ready for a randomly drawn pause
    always @(posedge i_clk) begin : sink_pace
        int unsigned hold;
        int unsigned wait_n;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            hold = 0;
        end else if (res.valid && res.ready) begin
            wait_n = snk_idle ? $urandom_range(0, 13) : 0;
            if (wait_n != 0) begin
                res.ready <= 1'b0;
                hold = wait_n - 1;
            end
        end else if (!res.ready) begin
            if (hold == 0) res.ready <= 1'b1;
            else hold = hold - 1;
        end
    end

    function automatic logic [7:0] b64_char(input int unsigned idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        if (idx == 62) return "+";
        return "/";
    endfunction

    function automatic logic [7:0] filler_char();
        if ($urandom_range(0, 1) == 0) return " ";
        return 8'($urandom_range(128, 255));
    endfunction

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic send_char(input logic [7:0] ch, input logic last);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            txt.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        txt.valid       <= 1'b1;
        txt.in_char     <= ch;
        txt.end_of_text <= last;
        do @(posedge i_clk); while (!txt.ready);
    endtask

    // Send the pending text as one string, flagging its last character
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic build_random_string();
        int unsigned style;
        int unsigned ngroups;
        int unsigned npad;
        style = $urandom_range(0, 11);
        if (style == 0) begin
            repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            ngroups = $urandom_range(1, 5);
            npad    = $urandom_range(0, 2);
            for (int g = 0; g < ngroups; g++) begin
                for (int k = 0; k < 4; k++) begin
                    if ($urandom_range(0, 11) == 0) text_q.push_back(filler_char());
                    if (g == ngroups - 1 && k >= 4 - npad) text_q.push_back("=");
                    else text_q.push_back(b64_char($urandom_range(0, 63)));
                end
            end
            // break a few strings: cut the last group, a symbol after a pad, an extra pad
            if (style == 1) begin
                repeat ($urandom_range(1, 3)) void'(text_q.pop_back());
            end else if (style == 2) begin
                text_q.push_back("=");
                text_q.push_back(b64_char($urandom_range(0, 63)));
            end else if (style == 3) begin
                text_q.push_back("=");
            end
        end
        if ($urandom_range(0, 3) == 0) text_q.push_back(filler_char());
    endtask

    task automatic wait_drained();
        txt.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Write out_capacity, then read it back
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_OUT_CAPACITY;
        pwdata  <= {(APB_DW - CAP_W)'($urandom()), cap};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [CAP_W-1:0] cap;
        int               sent;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        txt.valid       <= 1'b0;
        txt.in_char     <= '0;
        txt.end_of_text <= 1'b0;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed strings at the reset capacity
        push_str("TWFuTQ==");
        send_text();
        text_q.push_back(8'h00);
        push_str("+/9z");
        text_q.push_back(8'hFF);
        send_text();
        push_str("A===B");
        send_text();
        push_str("AB=C");
        send_text();
        push_str("AB");
        send_text();

        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            case (phase)
                0:       cap = 10'd1023;
                1:       cap = 10'd0;
                2:       cap = 10'd3;
                3:       cap = 10'd1;
                4:       cap = 10'd2;
                5:       cap = 10'd9;
                6:       cap = 10'($urandom_range(0, 1023));
                default: cap = 10'($urandom_range(4, 40));
            endcase
            set_capacity(cap);
            src_idle = (phase % 3 != 1);
            snk_idle = (phase % 4 != 2);
            sent = 0;
            while (sent < 4) begin
                build_random_string();
                sent += text_q.size();
                send_text();
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/b64d_pkg.sv
hdl/b64d_if.sv
hdl/b64d_front.sv
hdl/b64d_queue.sv
hdl/b64d_back.sv
hdl/base64_stream_decoder_top.sv
dv/b64d_stream_checker.sv
dv/tb_base64_stream_decoder_top.sv
